// ----- rtl/pfrq_pkg.sv -----
// Shared types and constants for the priority floor request queue.
// Used by pfrq_mem, pfrq_ctrl and priority_floor_request_queue; no dependencies.
package pfrq_pkg;

    // Default number of queue entries
    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    // Fixed field widths of the command and result words
    localparam int unsigned CAP_W  = 5;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned USER_W = 32;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 3'd0,
        OP_DEQ  = 3'd1,
        OP_PEEK = 3'd2,
        OP_REM  = 3'd3,
        OP_FIND = 3'd4,
        OP_CLR  = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_FWD
    } t_state;

    // One queue entry as stored in the memory
    typedef struct packed {
        logic [USER_W-1:0] user;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // One result word
    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [USER_W-1:0] found_user;
        logic [PRIO_W-1:0] found_priority;
        logic [POS_W-1:0]  count;
        logic              at_capacity;
        logic              enabled;
    } t_result;

endpackage

// ----- rtl/priority_floor_request_queue.sv -----
// Top level of the priority floor request queue: capacity register,
// command sequencer and entry store. Depends on pfrq_pkg, pfrq_ctrl, pfrq_mem.
//
// Usage:
//   Command channel: a command word (i_opcode, i_user_id, i_priority_req) is
//   taken at a clock edge where start is high and busy is low. busy stays high
//   while the command walks the entry store.
//   Result channel: o_valid is high for exactly one cycle with the result word
//   on o_status .. o_enabled. The receiver cannot stall; it must take the word
//   in that cycle. One result comes back for every command.
//   Capacity: written through i_cfg_we / i_cfg_wdata while the block is idle.
// Timing:
//   Clear, unused opcodes, an enqueue into an empty queue and refused or empty
//   commands answer in the cycle after acceptance. Other commands walk the entry
//   store, one entry per cycle, over the single read port of the memory: the
//   result follows the last entry visited (at most the count), and an enqueue
//   that lands at the head adds a write of the head entry. busy falls in the
//   cycle the result is shown, so the next command may be accepted then.
// Reset: i_rst_n (synchronous, low) empties the queue and sets capacity to 0,
//   which disables queueing until capacity is written. The entry store itself
//   is not cleared.
module priority_floor_request_queue
    import pfrq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [USER_W-1:0] i_user_id,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [POS_W-1:0]  o_position,
    output logic [USER_W-1:0] o_found_user,
    output logic [PRIO_W-1:0] o_found_priority,
    output logic [POS_W-1:0]  o_count,
    output logic              o_at_capacity,
    output logic              o_enabled
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [CAP_W-1:0] r_capacity;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_waddr;
    t_entry           w_mem_wdata;
    logic             w_mem_re;
    logic [AW-1:0]    w_mem_raddr;
    t_entry           w_mem_rdata;
    t_result          w_result;

    // Hold the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    pfrq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_opcode       (i_opcode),
        .i_user_id      (i_user_id),
        .i_priority_req (i_priority_req),
        .i_capacity     (r_capacity),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .o_result       (w_result),
        .o_mem_we       (w_mem_we),
        .o_mem_waddr    (w_mem_waddr),
        .o_mem_wdata    (w_mem_wdata),
        .o_mem_re       (w_mem_re),
        .o_mem_raddr    (w_mem_raddr),
        .i_mem_rdata    (w_mem_rdata)
    );

    pfrq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Unpack the result word
    assign o_status         = w_result.status;
    assign o_position       = w_result.position;
    assign o_found_user     = w_result.found_user;
    assign o_found_priority = w_result.found_priority;
    assign o_count          = w_result.count;
    assign o_at_capacity    = w_result.at_capacity;
    assign o_enabled        = w_result.enabled;

endmodule

// ----- rtl/pfrq_mem.sv -----
// Entry store of the request queue: one write port, one read port,
// registered read data. Depends on pfrq_pkg for the entry type.
module pfrq_mem
    import pfrq_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pfrq_ctrl.sv -----
// Command sequencer of the request queue: walks the entry store one entry
// a cycle to insert, remove or find. Depends on pfrq_pkg.
module pfrq_ctrl
    import pfrq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [USER_W-1:0] i_user_id,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic [CAP_W-1:0]  i_capacity,
    output logic              o_busy,
    output logic              o_valid,
    output t_result           o_result,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output t_entry            o_mem_wdata,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_raddr,
    input  t_entry            i_mem_rdata
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;

    t_state            r_state, n_state;
    t_opcode           r_op, n_op;
    logic [USER_W-1:0] r_id, n_id;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_k, n_k;
    logic              r_hit, n_hit;
    t_entry            r_hent, n_hent;
    logic [CW-1:0]     r_count, n_count;
    logic              r_valid;
    t_result           r_res;

    logic              w_accept;
    t_opcode           w_new_op;
    logic              w_full;
    logic              w_empty;
    logic              w_last;
    logic              w_first_hit;
    logic              w_removes;
    logic              w_ins_here;
    logic              w_fin;
    t_status           w_status;
    logic [CW-1:0]     w_pos;
    t_entry            w_ent;

    // Shared conditions
    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_new_op    = t_opcode'(i_opcode);
    assign w_empty     = (r_count == '0);
    assign w_full      = (i_capacity == '0) || (MW'(r_count) >= MW'(i_capacity)) ||
                         (r_count >= CW'(QUEUE_DEPTH));
    assign w_last      = (r_idx == AW'(r_count - 1'b1));
    assign w_first_hit = (r_op == OP_DEQ) || (r_op == OP_PEEK) ||
                         (i_mem_rdata.user == r_id);
    assign w_removes   = (r_op == OP_DEQ) || (r_op == OP_REM);
    assign w_ins_here  = (r_prio <= i_mem_rdata.prio);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_new_op)
                        OP_ENQ: begin
                            if (!w_full && !w_empty) n_state = S_INS;
                        end
                        OP_DEQ, OP_PEEK, OP_REM, OP_FIND: begin
                            if (!w_empty) n_state = S_FWD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (w_ins_here) n_state = S_IDLE;
                else if (r_idx == '0) n_state = S_PUT;
            end
            S_PUT: n_state = S_IDLE;
            S_FWD: begin
                if (!r_hit && w_first_hit && !w_removes) n_state = S_IDLE;
                else if (w_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory access and result
    always_comb begin
        n_op        = r_op;
        n_id        = r_id;
        n_prio      = r_prio;
        n_idx       = r_idx;
        n_k         = r_k;
        n_hit       = r_hit;
        n_hent      = r_hent;
        n_count     = r_count;
        w_fin       = 1'b0;
        w_status    = ST_OK;
        w_pos       = '0;
        w_ent       = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = w_new_op;
                    n_id   = i_user_id;
                    n_prio = i_priority_req;
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    case (w_new_op)
                        OP_ENQ: begin
                            if (w_full) begin
                                w_fin    = 1'b1;
                                w_status = ST_FULL;
                            end else if (w_empty) begin
                                // first entry goes straight to the head
                                o_mem_we    = 1'b1;
                                o_mem_waddr = '0;
                                o_mem_wdata = '{user: i_user_id, prio: i_priority_req};
                                n_count     = CW'(r_count + 1'b1);
                                w_fin       = 1'b1;
                                w_pos       = CW'(1);
                            end else begin
                                // walk from the tail toward the head
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(r_count - 1'b1);
                                n_idx       = AW'(r_count - 1'b1);
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (w_empty) begin
                                w_fin    = 1'b1;
                                w_status = ST_EMPTY;
                            end else begin
                                o_mem_re = 1'b1;
                            end
                        end
                        OP_REM, OP_FIND: begin
                            if (w_empty) begin
                                w_fin    = 1'b1;
                                w_status = ST_NOTFOUND;
                            end else begin
                                o_mem_re = 1'b1;
                            end
                        end
                        OP_CLR: begin
                            n_count = '0;
                            w_fin   = 1'b1;
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_idx + 1'b1);
                if (w_ins_here) begin
                    // new entry lands behind this one
                    o_mem_wdata = '{user: r_id, prio: r_prio};
                    n_count     = CW'(r_count + 1'b1);
                    w_fin       = 1'b1;
                    w_pos       = CW'(CW'(r_idx) + CW'(2));
                end else begin
                    // move this entry one place back
                    o_mem_wdata = i_mem_rdata;
                    if (r_idx != '0) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(r_idx - 1'b1);
                        n_idx       = AW'(r_idx - 1'b1);
                    end
                end
            end
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = '{user: r_id, prio: r_prio};
                n_count     = CW'(r_count + 1'b1);
                w_fin       = 1'b1;
                w_pos       = CW'(1);
            end
            S_FWD: begin
                if (r_hit) begin
                    // close the gap: move this entry one place forward
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(r_idx - 1'b1);
                    o_mem_wdata = i_mem_rdata;
                    if (w_last) begin
                        n_count = CW'(r_count - 1'b1);
                        w_fin   = 1'b1;
                        w_ent   = r_hent;
                        w_pos   = (r_op == OP_DEQ) ? '0 : CW'(CW'(r_k) + CW'(1));
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(r_idx + 1'b1);
                        n_idx       = AW'(r_idx + 1'b1);
                    end
                end else if (w_first_hit) begin
                    if (!w_removes || w_last) begin
                        // lookup done, or the hit was the tail entry
                        if (w_removes) n_count = CW'(r_count - 1'b1);
                        w_fin = 1'b1;
                        w_ent = i_mem_rdata;
                        w_pos = (r_op == OP_DEQ) ? '0 : CW'(CW'(r_idx) + CW'(1));
                    end else begin
                        n_hit       = 1'b1;
                        n_hent      = i_mem_rdata;
                        n_k         = r_idx;
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(r_idx + 1'b1);
                        n_idx       = AW'(r_idx + 1'b1);
                    end
                end else if (w_last) begin
                    w_fin    = 1'b1;
                    w_status = ST_NOTFOUND;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(r_idx + 1'b1);
                    n_idx       = AW'(r_idx + 1'b1);
                end
            end
            default: begin
                w_fin = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hit   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hit   <= n_hit;
            r_valid <= w_fin;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_id   <= n_id;
        r_prio <= n_prio;
        r_idx  <= n_idx;
        r_k    <= n_k;
        r_hent <= n_hent;
        if (w_fin) begin
            r_res.status         <= w_status;
            r_res.position       <= POS_W'(w_pos);
            r_res.found_user     <= w_ent.user;
            r_res.found_priority <= w_ent.prio;
            r_res.count          <= POS_W'(n_count);
            r_res.at_capacity    <= (MW'(n_count) >= MW'(i_capacity));
            r_res.enabled        <= (i_capacity != '0);
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("read and write of the same entry in one cycle");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_busy || r_valid))
        else $error("accepted command neither running nor answered");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe while a command is still running");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWD || r_state == S_INS) |-> (r_count != '0))
        else $error("entry walk on an empty queue");
`endif

endmodule

// ----- dv/priority_floor_request_queue_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for priority_floor_request_queue: directed and random command
// traffic, a behavioral copy of the queue predicts every result word. Depends on pfrq_pkg.
module priority_floor_request_queue_tb;
    import pfrq_pkg::*;

    localparam int unsigned DEPTH          = QUEUE_DEPTH_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 25;
    localparam int unsigned SEG_WORDS      = 130;
    localparam int unsigned SEGS_PER_PHASE = 5;
    // Opcodes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_opcode;
    logic [USER_W-1:0] i_user_id;
    logic [PRIO_W-1:0] i_priority_req;
    logic              i_cfg_we;
    logic [CAP_W-1:0]  i_cfg_wdata;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic [POS_W-1:0]  o_position;
    logic [USER_W-1:0] o_found_user;
    logic [PRIO_W-1:0] o_found_priority;
    logic [POS_W-1:0]  o_count;
    logic              o_at_capacity;
    logic              o_enabled;

    // Shadow copy of the queue and the capacity register
    logic [USER_W-1:0] shadow_user [DEPTH];
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    int unsigned       shadow_len;
    int unsigned       shadow_cap;

    t_result     pending_words[$];
    t_result     want_word;
    int unsigned err_count;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned refused_count;
    int unsigned empty_count;
    int unsigned missing_count;
    int unsigned stall_cycles;
    int unsigned sender_idle_pct;

    priority_floor_request_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_user_id        (i_user_id),
        .i_priority_req   (i_priority_req),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_position       (o_position),
        .o_found_user     (o_found_user),
        .o_found_priority (o_found_priority),
        .o_count          (o_count),
        .o_at_capacity    (o_at_capacity),
        .o_enabled        (o_enabled)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Remove one entry and close the gap
    function automatic void drop_entry(int unsigned idx);
        int unsigned i;
        for (i = idx; i + 1 < shadow_len; i++) begin
            shadow_user[i] = shadow_user[i + 1];
            shadow_prio[i] = shadow_prio[i + 1];
        end
        if (shadow_len > 0) shadow_len--;
    endfunction

    // Apply one command to the shadow queue and return the result word it yields
    function automatic t_result serve_request(logic [OP_W-1:0] op, logic [USER_W-1:0] id,
                                              logic [PRIO_W-1:0] pr);
        t_result     r;
        int unsigned k;
        int unsigned i;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQ: begin
                if (shadow_cap == 0 || shadow_len >= shadow_cap || shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    k = 0;
                    while (k < shadow_len && pr <= shadow_prio[k]) k++;
                    for (i = shadow_len; i > k; i--) begin
                        shadow_user[i] = shadow_user[i - 1];
                        shadow_prio[i] = shadow_prio[i - 1];
                    end
                    shadow_user[k] = id;
                    shadow_prio[k] = pr;
                    shadow_len++;
                    r.position = POS_W'(k + 1);
                end
            end
            OP_DEQ, OP_PEEK: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.found_user     = shadow_user[0];
                    r.found_priority = shadow_prio[0];
                    if (op == OP_DEQ) drop_entry(0);
                    else r.position = POS_W'(1);
                end
            end
            OP_REM, OP_FIND: begin
                k = 0;
                while (k < shadow_len && shadow_user[k] != id) k++;
                if (k >= shadow_len) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.found_user     = shadow_user[k];
                    r.found_priority = shadow_prio[k];
                    r.position       = POS_W'(k + 1);
                    if (op == OP_REM) drop_entry(k);
                end
            end
            OP_CLR: shadow_len = 0;
            default: ;
        endcase
        r.count       = POS_W'(shadow_len);
        r.at_capacity = (shadow_len >= shadow_cap);
        r.enabled     = (shadow_cap != 0);
        return r;
    endfunction

    // Drive one command word and hold it until the block takes it
    task automatic send_word(logic [OP_W-1:0] op, logic [USER_W-1:0] id,
                             logic [PRIO_W-1:0] pr);
        @(negedge i_clk);
        // Idle the sender cycle by cycle at the chosen rate
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start          = 1'b1;
        i_opcode       = op;
        i_user_id      = id;
        i_priority_req = pr;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_words.push_back(serve_request(op, id, pr));
        words_sent++;
    endtask

    // Drop start and hold until every outstanding result word has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // Write the capacity register; the block is idle here
    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        shadow_cap = value;
    endtask

    task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, exp_v, got_v);
        end
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_words.size() == 0) begin
                err_count++;
                $display("%0t: result word with nothing pending, status %0d count %0d",
                         $time, o_status, o_count);
            end else begin
                want_word = pending_words[0];
                pending_words.delete(0);
                check_field("status", want_word.status, o_status);
                check_field("position", want_word.position, o_position);
                check_field("found_user", want_word.found_user, o_found_user);
                check_field("found_priority", want_word.found_priority, o_found_priority);
                check_field("count", want_word.count, o_count);
                check_field("at_capacity", want_word.at_capacity, o_at_capacity);
                check_field("enabled", want_word.enabled, o_enabled);
                words_checked++;
                if (want_word.status == ST_FULL) refused_count++;
                if (want_word.status == ST_EMPTY) empty_count++;
                if (want_word.status == ST_NOTFOUND) missing_count++;
            end
        end
    end

    // Watchdog: end the run if neither side moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Disabled queue after reset: every opcode, empty and missing cases
    task automatic test_idle_defaults();
        send_word(OP_ENQ, 32'h0000_0001, 8'h10);
        send_word(OP_DEQ, '0, '0);
        send_word(OP_PEEK, '0, '0);
        send_word(OP_REM, '0, '0);
        send_word(OP_FIND, 32'hFFFF_FFFF, '0);
        send_word(OP_CLR, '0, '0);
        send_word(OP_SPARE_LO, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_SPARE_HI, '0, '0);
    endtask

    // Service order: ties keep arrival order, duplicates, full refusal, first match wins
    task automatic test_service_order();
        write_capacity(CAP_W'(4));
        send_word(OP_ENQ, 32'd5, 8'h80);
        send_word(OP_ENQ, 32'd7, 8'hFF);
        send_word(OP_ENQ, 32'd9, 8'h80);
        send_word(OP_ENQ, 32'd5, 8'h00);
        send_word(OP_ENQ, 32'd11, 8'hFF);
        send_word(OP_FIND, 32'd5, '0);
        send_word(OP_REM, 32'd5, '0);
        send_word(OP_PEEK, '0, '0);
        send_word(OP_DEQ, '0, '0);
    endtask

    // Capacity lowered below the count, then raised to the field maximum
    task automatic test_capacity_change();
        write_capacity(CAP_W'(1));
        send_word(OP_ENQ, 32'd3, 8'h40);
        write_capacity(CAP_W'(31));
        send_word(OP_ENQ, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_REM, 32'h0, '0);
        send_word(OP_CLR, '0, '0);
    endtask

    // Random traffic over several capacity settings
    task automatic test_random_traffic(int unsigned idle_pct);
        int unsigned       seg;
        int unsigned       n;
        int unsigned       enq_w;
        int unsigned       roll;
        logic [OP_W-1:0]   op;
        logic [USER_W-1:0] id;
        logic [PRIO_W-1:0] pr;
        sender_idle_pct = idle_pct;
        for (seg = 0; seg < SEGS_PER_PHASE; seg++) begin
            case (seg)
                0: write_capacity(CAP_W'(DEPTH));
                1: write_capacity(CAP_W'(31));
                2: write_capacity(CAP_W'($urandom_range(1, 6)));
                3: write_capacity(CAP_W'($urandom_range(0, 31)));
                default: write_capacity(CAP_W'($urandom_range(7, DEPTH)));
            endcase
            // Lean toward filling or toward draining, per segment
            case ($urandom_range(0, 2))
                0: enq_w = 20;
                1: enq_w = 40;
                default: enq_w = 60;
            endcase
            for (n = 0; n < SEG_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < enq_w) begin
                    op = OP_ENQ;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 26) op = OP_DEQ;
                    else if (roll < 42) op = OP_PEEK;
                    else if (roll < 66) op = OP_REM;
                    else if (roll < 90) op = OP_FIND;
                    else if (roll < 94) op = OP_CLR;
                    else if (roll < 97) op = OP_SPARE_LO;
                    else op = OP_SPARE_HI;
                end
                // Mostly ids already queued or from a small pool, so hits and duplicates occur
                if ((op == OP_REM || op == OP_FIND) && shadow_len > 0
                        && $urandom_range(0, 99) < 75) begin
                    id = shadow_user[$urandom_range(0, shadow_len - 1)];
                end else if ($urandom_range(0, 99) < 60) begin
                    id = USER_W'($urandom_range(1, 12));
                end else begin
                    id = $urandom;
                end
                if ($urandom_range(0, 1) == 0) pr = PRIO_W'($urandom_range(0, 3) * 85);
                else pr = PRIO_W'($urandom_range(0, 255));
                send_word(op, id, pr);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = '0;
        i_user_id       = '0;
        i_priority_req  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        shadow_len      = 0;
        shadow_cap      = 0;
        err_count       = 0;
        words_sent      = 0;
        words_checked   = 0;
        refused_count   = 0;
        empty_count     = 0;
        missing_count   = 0;
        sender_idle_pct = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_defaults();
        test_service_order();
        test_capacity_change();
        test_random_traffic(25);
        test_random_traffic(67);
        test_random_traffic(0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d command words, checked %0d result words over capacities 0 to 31",
                 words_sent, words_checked);
        $display("Refused enqueues %0d, empty-queue replies %0d, ids not found %0d",
                 refused_count, empty_count, missing_count);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- priority_floor_request_queue.f -----
rtl/pfrq_pkg.sv
rtl/pfrq_mem.sv
rtl/pfrq_ctrl.sv
rtl/priority_floor_request_queue.sv
dv/priority_floor_request_queue_tb.sv
